// ===== hw/rtl/jsmc_pkg.sv =====
// Shared constants and types of the joystick servo mode controller.
package jsmc_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned DutyW   = 10;
  localparam int unsigned ThrW    = 4;

  // Largest servo compare value; every duty is clipped to it.
  localparam logic [DutyW-1:0] DutyMax   = 10'd625;
  localparam logic [DutyW-1:0] DutyReset = 10'd45;

  // Division by 17 as a multiply by ceil(2^16 / 17) and a shift by 16. The
  // reciprocal overshoots by under 1/65536 per unit, staying below the gap
  // to the next integer for every 10-bit sample, so the quotient is exact.
  localparam int unsigned    RecipW   = 12;
  localparam logic [RecipW-1:0] DivRecip = 12'd3856;
  localparam int unsigned    DivShift = 16;
  localparam int unsigned    QuotW    = 6;

  // Duty candidates for one conversion beat.
  typedef struct packed {
    logic [DutyW-1:0] duty;    // scaled sample plus offset, clipped
    logic [DutyW-1:0] centre;  // centre setting, clipped
  } duty_pair_t;

endpackage

// ===== hw/rtl/jsmc_duty.sv =====
// Scaling of a joystick sample to a servo duty, with clipping of both candidates.
module jsmc_duty (
  input  logic [jsmc_pkg::SampleW-1:0] sample_i,
  input  logic [jsmc_pkg::DutyW-1:0]   offset_i,
  input  logic [jsmc_pkg::DutyW-1:0]   centre_i,
  output jsmc_pkg::duty_pair_t         pair_o
);

  logic [jsmc_pkg::SampleW+jsmc_pkg::RecipW-1:0] prod;
  logic [jsmc_pkg::QuotW-1:0]                   quot;
  logic [jsmc_pkg::DutyW:0]                     sum;

  assign prod = {{jsmc_pkg::RecipW{1'b0}}, sample_i} *
                {{jsmc_pkg::SampleW{1'b0}}, jsmc_pkg::DivRecip};
  assign quot = prod[jsmc_pkg::DivShift +: jsmc_pkg::QuotW];
  assign sum  = {{(jsmc_pkg::DutyW+1-jsmc_pkg::QuotW){1'b0}}, quot} + {1'b0, offset_i};

  always_comb begin
    pair_o.duty   = (sum > {1'b0, jsmc_pkg::DutyMax}) ? jsmc_pkg::DutyMax
                                                      : sum[jsmc_pkg::DutyW-1:0];
    pair_o.centre = (centre_i > jsmc_pkg::DutyMax) ? jsmc_pkg::DutyMax : centre_i;
  end

endmodule

// ===== hw/rtl/joystick_servo_mode_controller.sv =====
// Top level of the joystick servo mode controller: beat handshakes, state and result register.
//
// The block takes one beat per clock cycle when the output side is not stalled and returns
// exactly one result beat for each. A beat is first held in an input register; once the
// output register is free or being emptied, the phase sequencer, the debounce counter,
// the mode and the servo duties are updated and the result is captured in the output
// register, so a beat that follows immediately already sees the updated state. The rate
// of one beat per cycle is set by that single update step together with the two-entry
// path (input register, output register); a stalled output holds one result while a
// further beat waits in the input register, after which s_axis_tready falls. Tick beats
// (tuser low) step through the button check, start-X and start-Y phases; conversion beats
// (tuser high) scale the sample by 1/17, add the offset, clip at 625 and steer it to the
// servo duties according to the mode. Configuration writes take effect at once and are
// expected only while no beat is in flight.
module joystick_servo_mode_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: 0 centre duty, 1 duty offset, 2 debounce threshold.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [0] button_pressed, [10:1] sample, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] operation: 0 tick, 1 conversion done
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [9:0] duty_x, [19:10] duty_y, [20] start_conversion,
                                      // [21] channel, [23:22] current_mode
);

  localparam logic [1:0] CfgCentre    = 2'd0;
  localparam logic [1:0] CfgOffset    = 2'd1;
  localparam logic [1:0] CfgThreshold = 2'd2;

  localparam logic OpTick = 1'b0;

  localparam logic [1:0] ModeBoth   = 2'd0;
  localparam logic [1:0] ModeXOnly  = 2'd1;
  localparam logic [1:0] ModeYOnly  = 2'd2;

  typedef enum logic [1:0] {
    PhCheck  = 2'd0,
    PhStartX = 2'd1,
    PhStartY = 2'd2
  } phase_e;

  // Configuration registers.
  logic [jsmc_pkg::DutyW-1:0] centre_q;
  logic [jsmc_pkg::DutyW-1:0] offset_q;
  logic [jsmc_pkg::ThrW-1:0]  thr_q;

  // Input register.
  logic                         in_valid_q;
  logic                         in_op_q;
  logic                         in_pressed_q;
  logic [jsmc_pkg::SampleW-1:0] in_sample_q;

  // Controller state.
  phase_e                     phase_q, phase_d;
  logic [jsmc_pkg::ThrW-1:0]  press_q, press_d;
  logic [1:0]                 mode_q, mode_d;
  logic                       samp_x_q, samp_x_d;
  logic [jsmc_pkg::DutyW-1:0] x_duty_q, x_duty_d;
  logic [jsmc_pkg::DutyW-1:0] y_duty_q, y_duty_d;

  // Output register.
  logic        out_valid_q;
  logic [23:0] out_data_q, out_data_d;

  logic                       advance;
  logic                       take;
  logic                       start;
  logic [jsmc_pkg::ThrW-1:0]  press_inc;
  jsmc_pkg::duty_pair_t       pair;

  // The held beat moves on whenever the result register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  jsmc_duty u_duty (
    .sample_i (in_sample_q),
    .offset_i (offset_q),
    .centre_i (centre_q),
    .pair_o   (pair)
  );

  assign press_inc = press_q + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    press_d  = press_q;
    mode_d   = mode_q;
    samp_x_d = samp_x_q;
    x_duty_d = x_duty_q;
    y_duty_d = y_duty_q;
    start    = 1'b0;
    if (advance) begin
      if (in_op_q == OpTick) begin
        unique case (phase_q)
          PhCheck: begin
            // The count survives a release; only passing the threshold clears it.
            if (in_pressed_q) begin
              if (press_inc > thr_q) begin
                press_d = '0;
                mode_d  = mode_q + 1'b1;
              end else begin
                press_d = press_inc;
              end
            end
            phase_d = PhStartX;
          end
          PhStartX: begin
            samp_x_d = 1'b1;
            start    = 1'b1;
            phase_d  = PhStartY;
          end
          PhStartY: begin
            samp_x_d = 1'b0;
            start    = 1'b1;
            phase_d  = PhCheck;
          end
          default: begin
            phase_d = PhCheck;
          end
        endcase
      end else begin
        case (mode_q)
          ModeBoth: begin
            if (samp_x_q) begin
              x_duty_d = pair.duty;
            end else begin
              y_duty_d = pair.duty;
            end
          end
          ModeXOnly: begin
            if (samp_x_q) begin
              x_duty_d = pair.duty;
              y_duty_d = pair.centre;
            end
          end
          ModeYOnly: begin
            if (!samp_x_q) begin
              y_duty_d = pair.duty;
              x_duty_d = pair.centre;
            end
          end
          default: begin
            // Frozen: both duties hold.
          end
        endcase
      end
    end
    out_data_d = {mode_d, ~samp_x_d, start, y_duty_d, x_duty_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q    <= jsmc_pkg::DutyReset;
      offset_q    <= 10'd15;
      thr_q       <= 4'd2;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhCheck;
      press_q     <= '0;
      mode_q      <= ModeBoth;
      samp_x_q    <= 1'b1;
      x_duty_q    <= jsmc_pkg::DutyReset;
      y_duty_q    <= jsmc_pkg::DutyReset;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgCentre:    centre_q <= cfg_data_i;
          CfgOffset:    offset_q <= cfg_data_i;
          CfgThreshold: thr_q    <= cfg_data_i[jsmc_pkg::ThrW-1:0];
          default: begin
            // Writes beyond the register list are dropped.
          end
        endcase
      end
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      phase_q  <= phase_d;
      press_q  <= press_d;
      mode_q   <= mode_d;
      samp_x_q <= samp_x_d;
      x_duty_q <= x_duty_d;
      y_duty_q <= y_duty_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_op_q      <= s_axis_tuser[0];
      in_pressed_q <= s_axis_tdata[0];
      in_sample_q  <= s_axis_tdata[jsmc_pkg::SampleW:1];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // The mode only moves on a tick beat processed in the button check phase.
  a_mode_moves_on_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && (in_op_q == OpTick) && (phase_q == PhCheck)) |=> $stable(mode_q))
    else $error("mode changed outside a check-phase tick");

  // Servo duties only move on conversion beats.
  a_duty_moves_on_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && (in_op_q != OpTick)) |=> ($stable(x_duty_q) && $stable(y_duty_q)))
    else $error("duty changed without a conversion beat");

  // Back-pressure on the input only arises with a beat held in the input register.
  a_ready_low_means_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // A result is produced for every beat leaving the input register.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed beat produced no result");

endmodule

// ===== bench/joystick_servo_mode_controller_test.sv =====
// Self-checking testbench for the joystick servo mode controller.
`timescale 1ns / 100ps

module joystick_servo_mode_controller_test;

  // The limit below only catches a hung handshake.
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned SampleDivisor = 17;
  // The block answers through an input register and an output register. The
  // settle time at the end of the run comes on top of that.
  localparam int unsigned SettleCycles  = 10;

  // tuser value of an input beat.
  typedef enum logic {
    OpTick = 1'b0,
    OpConv = 1'b1
  } beat_op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegCentreDuty  = 2'd0,
    RegDutyOffset  = 2'd1,
    RegDebounceThr = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PhCheck  = 2'd0,
    PhStartX = 2'd1,
    PhStartY = 2'd2,
    PhUnused = 2'd3
  } tick_phase_e;

  typedef enum logic [1:0] {
    ModeBoth   = 2'd0,
    ModeXOnly  = 2'd1,
    ModeYOnly  = 2'd2,
    ModeFrozen = 2'd3
  } servo_mode_e;

  typedef struct {
    beat_op_e                     op;
    logic                         pressed;
    logic [jsmc_pkg::SampleW-1:0] sample;
  } joy_beat_t;

  // Laid out as on m_axis_tdata, highest field first.
  typedef struct packed {
    logic [1:0]                 mode;
    logic                       channel;
    logic                       start;
    logic [jsmc_pkg::DutyW-1:0] duty_y;
    logic [jsmc_pkg::DutyW-1:0] duty_x;
  } servo_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [9:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  joystick_servo_mode_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Beats waiting to be sent, and the reports that accepted beats must yield,
  // oldest first.
  joy_beat_t     pending_q[$];
  servo_report_t report_q[$];
  int unsigned   err_count;
  int unsigned   cycle_count;

  // Our own copy of the controller: settings and state.
  logic [jsmc_pkg::DutyW-1:0] centre_set;
  logic [jsmc_pkg::DutyW-1:0] offset_set;
  logic [jsmc_pkg::ThrW-1:0]  thr_set;
  tick_phase_e                ctl_phase;
  logic [jsmc_pkg::ThrW-1:0]  press_cnt;
  servo_mode_e                ctl_mode;
  logic                       sampling_x;
  logic [jsmc_pkg::DutyW-1:0] x_duty;
  logic [jsmc_pkg::DutyW-1:0] y_duty;

  // Sender and receiver pacing.
  joy_beat_t   beat_on_bus;
  int          burst_left;
  int          gap_left;
  logic [31:0] stall_pat;
  int          pat_age;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("[joystick_servo_mode_controller] ERROR");
      $finish;
    end
  end

  // Duties never exceed the servo maximum; the centre setting is clipped too.
  function automatic logic [jsmc_pkg::DutyW-1:0] clip_duty(logic [jsmc_pkg::DutyW:0] v);
    return (v > {1'b0, jsmc_pkg::DutyMax}) ? jsmc_pkg::DutyMax : v[jsmc_pkg::DutyW-1:0];
  endfunction

  // Moves our copy of the controller on by one accepted beat and records the
  // report the block owes for it.
  task automatic advance_controller(joy_beat_t b);
    servo_report_t              r;
    logic [jsmc_pkg::DutyW-1:0] duty;
    logic [jsmc_pkg::DutyW-1:0] centre;
    r.start = 1'b0;
    if (b.op == OpTick) begin
      case (ctl_phase)
        PhCheck: begin
          // The count is only ever cleared by a mode change, never by release.
          // With the threshold at its top value it wraps and the mode stays.
          if (b.pressed) begin
            press_cnt = press_cnt + 1'b1;
            if (press_cnt > thr_set) begin
              press_cnt = '0;
              ctl_mode  = servo_mode_e'(ctl_mode + 2'd1);
            end
          end
          ctl_phase = PhStartX;
        end
        PhStartX: begin
          sampling_x = 1'b1;
          r.start    = 1'b1;
          ctl_phase  = PhStartY;
        end
        PhStartY: begin
          sampling_x = 1'b0;
          r.start    = 1'b1;
          ctl_phase  = PhCheck;
        end
        default: begin
          ctl_phase = PhCheck;
        end
      endcase
    end else begin
      duty   = clip_duty(11'({1'b0, offset_set} + (b.sample / SampleDivisor)));
      centre = clip_duty({1'b0, centre_set});
      case (ctl_mode)
        ModeBoth: begin
          if (sampling_x) x_duty = duty;
          else y_duty = duty;
        end
        // A locked axis is pulled to the centre only when the followed axis
        // gets a sample; a sample of the locked axis changes nothing.
        ModeXOnly: begin
          if (sampling_x) begin
            x_duty = duty;
            y_duty = centre;
          end
        end
        ModeYOnly: begin
          if (!sampling_x) begin
            y_duty = duty;
            x_duty = centre;
          end
        end
        default: begin
        end
      endcase
    end
    r.duty_x  = x_duty;
    r.duty_y  = y_duty;
    r.channel = ~sampling_x;
    r.mode    = ctl_mode;
    report_q.push_back(r);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_report(servo_report_t got);
    servo_report_t want;
    if (report_q.size() == 0) begin
      $display("%0t: result beat 0x%06h arrived with nothing expected", $time, got);
      err_count++;
    end else begin
      want = report_q.pop_front();
      compare_field("duty_x", want.duty_x, got.duty_x);
      compare_field("duty_y", want.duty_y, got.duty_y);
      compare_field("start_conversion", want.start, got.start);
      compare_field("channel", want.channel, got.channel);
      compare_field("current_mode", want.mode, got.mode);
    end
  endtask

  // Driver: sends pending beats in bursts of random length with random gaps in
  // between. A beat stays on the bus until the block takes it, and the next one
  // follows in the same cycle when the burst allows.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) advance_controller(beat_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // About one burst in three follows the previous one back to back.
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0 || pending_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          beat_on_bus = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, beat_on_bus.sample, beat_on_bus.pressed};
          s_axis_tuser  <= beat_on_bus.op;
          burst_left--;
        end
      end
    end
  end

  // Monitor: checks every accepted result beat and stalls on a rotating
  // pattern, drawn anew when its age count runs out. Some patterns never stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_pat = '1;
      pat_age   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
      if (pat_age == 0) begin
        pat_age = 64;
        case ($urandom_range(0, 2))
          0:       stall_pat = '1;
          1:       stall_pat = $urandom | 32'h1;
          default: stall_pat = ($urandom & $urandom) | 32'h1;
        endcase
      end
      pat_age--;
      m_axis_tready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[31:1]};
    end
  end

  function automatic void queue_beat(beat_op_e op, logic pressed,
                                     logic [jsmc_pkg::SampleW-1:0] smp);
    joy_beat_t b;
    b.op      = op;
    b.pressed = pressed;
    b.sample  = smp;
    pending_q.push_back(b);
  endfunction

  // Samples lean towards the ends of the range and the edges of the divide.
  function automatic logic [jsmc_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? '1 : '0;
      1:       return 10'(SampleDivisor * $urandom_range(0, 59) +
                          ($urandom_range(0, 1) ? 16 : 0));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // Mostly whole rounds of check tick, X start, X sample, Y start, Y sample,
  // so that the debounce count and the modes get exercised; the rest are loose
  // beats that knock the rounds out of step with the phase sequencer.
  task automatic queue_joystick_traffic(int n, int press_pct);
    int queued;
    queued = 0;
    while (queued < n) begin
      if ($urandom_range(0, 3) != 0) begin
        queue_beat(OpTick, $urandom_range(0, 99) < press_pct, pick_sample());
        queue_beat(OpTick, 1'($urandom_range(0, 1)), pick_sample());
        queue_beat(OpConv, 1'($urandom_range(0, 1)), pick_sample());
        queue_beat(OpTick, 1'($urandom_range(0, 1)), pick_sample());
        queue_beat(OpConv, 1'($urandom_range(0, 1)), pick_sample());
        queued += 5;
      end else begin
        queue_beat(beat_op_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   pick_sample());
        queued++;
      end
    end
  endtask

  // Waits until every beat has been sent and answered, so that the
  // block is idle.
  task automatic wait_for_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || report_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      RegCentreDuty:  centre_set = val;
      RegDutyOffset:  offset_set = val;
      RegDebounceThr: thr_set    = val[jsmc_pkg::ThrW-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(logic [9:0] centre, logic [9:0] offset, logic [3:0] thr);
    wait_for_idle();
    write_register(RegCentreDuty, centre);
    write_register(RegDutyOffset, offset);
    write_register(RegDebounceThr, {6'b0, thr});
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegCentreDuty;
    cfg_data_i    = '0;
    err_count     = 0;
    cycle_count   = 0;
    centre_set    = jsmc_pkg::DutyReset;
    offset_set    = 10'd15;
    thr_set       = 4'd2;
    ctl_phase     = PhCheck;
    press_cnt     = '0;
    ctl_mode      = ModeBoth;
    sampling_x    = 1'b1;
    x_duty        = jsmc_pkg::DutyReset;
    y_duty        = jsmc_pkg::DutyReset;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Settings as left by reset. Samples at the top end, just below and at a
    // multiple of 17, a full phase cycle, and three presses that take the
    // mode to X only, followed by an X sample that centres Y.
    queue_beat(OpConv, 1'b0, 10'd1023);
    queue_beat(OpTick, 1'b1, 10'd0);
    queue_beat(OpTick, 1'b0, 10'd0);
    queue_beat(OpConv, 1'b0, 10'd16);
    queue_beat(OpTick, 1'b0, 10'd0);
    queue_beat(OpConv, 1'b0, 10'd17);
    queue_beat(OpTick, 1'b1, 10'd0);
    queue_beat(OpTick, 1'b0, 10'd0);
    queue_beat(OpTick, 1'b0, 10'd0);
    queue_beat(OpTick, 1'b1, 10'd0);
    queue_beat(OpTick, 1'b0, 10'd0);
    queue_beat(OpConv, 1'b0, 10'd1023);

    // Centre and offset at their full width, so both clip at the maximum, and
    // a zero threshold so that every pressed check tick changes the mode. This
    // walks X only with a Y sample, Y only with both samples, frozen, and the
    // wrap back to following both axes.
    apply_settings(10'd1023, 10'd1023, 4'd0);
    queue_beat(OpTick, 1'b0, 10'd0);
    queue_beat(OpConv, 1'b0, 10'd300);
    queue_beat(OpTick, 1'b1, 10'd0);
    queue_beat(OpTick, 1'b0, 10'd0);
    queue_beat(OpConv, 1'b0, 10'd500);
    queue_beat(OpTick, 1'b0, 10'd0);
    queue_beat(OpConv, 1'b0, 10'd0);
    queue_beat(OpTick, 1'b1, 10'd0);
    queue_beat(OpTick, 1'b0, 10'd0);
    queue_beat(OpConv, 1'b0, 10'd1023);
    queue_beat(OpTick, 1'b0, 10'd0);
    queue_beat(OpTick, 1'b1, 10'd0);
    queue_beat(OpConv, 1'b1, 10'd700);

    // Random traffic under a series of settings: all zero, the top of the
    // documented ranges, full width with a threshold of 15 so the count wraps
    // and the mode never moves, the reset values, and two random settings.
    apply_settings(10'd0, 10'd0, 4'd0);
    queue_joystick_traffic(180, 50);
    apply_settings(10'd625, 10'd565, 4'd14);
    queue_joystick_traffic(180, 90);
    apply_settings(10'd1023, 10'd1023, 4'd15);
    queue_joystick_traffic(180, 80);
    apply_settings(jsmc_pkg::DutyReset, 10'd15, 4'd2);
    queue_joystick_traffic(180, 50);
    apply_settings(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                   4'($urandom_range(0, 15)));
    queue_joystick_traffic(180, 60);
    apply_settings(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                   4'($urandom_range(0, 15)));
    queue_joystick_traffic(180, 70);

    wait_for_idle();
    repeat (SettleCycles) @(negedge clk_i);
    if (err_count == 0) begin
      $display("[joystick_servo_mode_controller] OK");
    end else begin
      $display("[joystick_servo_mode_controller] ERROR");
    end
    $finish;
  end

endmodule
